/* rtl/core/blh_pkg.sv */
package blh_pkg;

    localparam int MAX_BOUNDS_DEF = 16;
    localparam int BOUND_SLOTS    = 16;
    localparam int BOUND_W        = 16;
    localparam int SLOT_W         = 4;
    localparam int WORD_W         = 64;
    localparam int VAL_W          = 32;
    localparam int SUM_W          = 64;
    localparam int ACT_W          = 5;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int PCT_W          = 7;
    localparam int PROD_W         = 39;
    localparam int Q_DEPTH        = 4;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD   = 2'd0,
        OP_SNAPSHOT = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOUND_0 = 3'd0,
        REG_BOUND_1 = 3'd1,
        REG_BOUND_2 = 3'd2,
        REG_BOUND_3 = 3'd3,
        REG_ACTIVE  = 3'd4
    } t_reg;

    typedef logic [BOUND_SLOTS-1:0][BOUND_W-1:0] t_bounds;

    localparam logic [WORD_W-1:0] BOUND_WORD_0_RST = 64'h000A_0005_0002_0001;
    localparam logic [WORD_W-1:0] BOUND_WORD_1_RST = 64'h00FA_0064_0032_0014;
    localparam logic [WORD_W-1:0] BOUND_WORD_2_RST = 64'h1388_09C4_03E8_01F4;
    localparam logic [WORD_W-1:0] BOUND_WORD_3_RST = 64'hFFFF_FFFF_FFFF_2710;
    localparam logic [ACT_W-1:0]  ACTIVE_RST       = 5'd13;

    localparam logic [PCT_W-1:0]  PCT_P50   = 7'd50;
    localparam logic [PCT_W-1:0]  PCT_P95   = 7'd95;
    localparam logic [PCT_W-1:0]  PCT_P99   = 7'd99;
    localparam logic [PCT_W-1:0]  PCT_ROUND = 7'd99;
    localparam logic [PCT_W-1:0]  PCT_DIV   = 7'd100;

endpackage

/* rtl/core/bucketed_latency_histogram_core.sv */
// Latency histogram with bucket-based percentile estimates.
// The input channel carries one operation per beat: record a sample, read a
// snapshot, or clear all statistics. Only a snapshot produces an output beat.
// The configuration channel writes the four bound words and the active bound
// count; it is always ready and is meant to be written while the block is idle.
// The front end classifies each sample against the bounds in the cycle it is
// accepted and pushes it into a four-entry queue, so records flow at one beat
// per cycle while the queue has room. The back end applies a record through a
// read-modify-write of the bucket count memory.
// A snapshot waits for pending records, then runs a bit-serial divider for
// the mean and a bucket walk that reads and then accumulates each bucket;
// an empty one skips both and goes straight to its result.
// While it runs the queue fills and input ready drops once it is full.
// The result sits in an output register until the receiver takes it; a later
// snapshot is computed and then holds the back end until that register drains.
// Reset restores the default bounds and empties all statistics.
module bucketed_latency_histogram_core #(
    parameter int MAX_BOUNDS = blh_pkg::MAX_BOUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [blh_pkg::OP_W-1:0]      i_in_op,
    input  logic [blh_pkg::VAL_W-1:0]     i_in_sample_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [blh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blh_pkg::WORD_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [blh_pkg::VAL_W-1:0]     o_out_sample_count,
    output logic [blh_pkg::SUM_W-1:0]     o_out_value_sum,
    output logic [blh_pkg::VAL_W-1:0]     o_out_smallest,
    output logic [blh_pkg::VAL_W-1:0]     o_out_largest,
    output logic [blh_pkg::VAL_W-1:0]     o_out_average,
    output logic [blh_pkg::VAL_W-1:0]     o_out_median_estimate,
    output logic [blh_pkg::VAL_W-1:0]     o_out_p95_estimate,
    output logic [blh_pkg::VAL_W-1:0]     o_out_p99_estimate,
    output logic                          o_out_is_empty
);

    localparam int IDX_W  = $clog2(MAX_BOUNDS + 1);
    localparam int DATA_W = blh_pkg::OP_W + blh_pkg::VAL_W + IDX_W;

    blh_pkg::t_bounds            r_bounds;
    logic [blh_pkg::ACT_W-1:0]   r_active;
    logic [IDX_W-1:0]            w_nb;
    logic                        w_push;
    logic [DATA_W-1:0]           w_item;
    logic                        w_q_full;
    logic                        w_q_empty;
    logic                        w_pop;
    logic [DATA_W-1:0]           w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds <= {blh_pkg::BOUND_WORD_3_RST, blh_pkg::BOUND_WORD_2_RST,
                         blh_pkg::BOUND_WORD_1_RST, blh_pkg::BOUND_WORD_0_RST};
            r_active <= blh_pkg::ACTIVE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                blh_pkg::REG_BOUND_0: r_bounds[3:0]   <= i_cfg_data;
                blh_pkg::REG_BOUND_1: r_bounds[7:4]   <= i_cfg_data;
                blh_pkg::REG_BOUND_2: r_bounds[11:8]  <= i_cfg_data;
                blh_pkg::REG_BOUND_3: r_bounds[15:12] <= i_cfg_data;
                blh_pkg::REG_ACTIVE:  r_active <= i_cfg_data[blh_pkg::ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_active == '0) begin
            w_nb = IDX_W'(1);
        end else if (r_active > blh_pkg::ACT_W'(MAX_BOUNDS)) begin
            w_nb = IDX_W'(MAX_BOUNDS);
        end else begin
            w_nb = IDX_W'(r_active);
        end
    end

    blh_front #(
        .MAX_BOUNDS (MAX_BOUNDS),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_in_op),
        .i_value    (i_in_sample_value),
        .i_bounds   (r_bounds),
        .i_nb       (w_nb),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    blh_fifo #(
        .DATA_W (DATA_W),
        .DEPTH  (blh_pkg::Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    blh_back #(
        .MAX_BOUNDS (MAX_BOUNDS),
        .IDX_W      (IDX_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_q_data          (w_q_data),
        .o_pop             (w_pop),
        .i_bounds          (r_bounds),
        .i_nb              (w_nb),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_sample_count    (o_out_sample_count),
        .o_value_sum       (o_out_value_sum),
        .o_smallest        (o_out_smallest),
        .o_largest         (o_out_largest),
        .o_average         (o_out_average),
        .o_median_estimate (o_out_median_estimate),
        .o_p95_estimate    (o_out_p95_estimate),
        .o_p99_estimate    (o_out_p99_estimate),
        .o_is_empty        (o_out_is_empty)
    );

`ifndef ASSERT_OFF
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_is_empty |->
            (o_out_sample_count == '0) && (o_out_average == '0) &&
            (o_out_median_estimate == '0) && (o_out_p99_estimate == '0))
        else $error("Empty snapshot beat carries nonzero statistics.");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_is_empty |-> o_out_smallest <= o_out_largest)
        else $error("Snapshot minimum exceeds maximum.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full && !w_pop |=> w_q_full)
        else $error("Queue lost an entry while full.");
`endif

endmodule

/* rtl/core/blh_fifo.sv */
module blh_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = blh_pkg::Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

/* rtl/core/blh_front.sv */
module blh_front #(
    parameter int MAX_BOUNDS = blh_pkg::MAX_BOUNDS_DEF,
    parameter int IDX_W      = $clog2(MAX_BOUNDS + 1)
) (
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [blh_pkg::OP_W-1:0]             i_op,
    input  logic [blh_pkg::VAL_W-1:0]            i_value,
    input  blh_pkg::t_bounds                     i_bounds,
    input  logic [IDX_W-1:0]                     i_nb,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output logic [blh_pkg::OP_W+blh_pkg::VAL_W+IDX_W-1:0] o_item
);

    logic [IDX_W-1:0] w_idx;

    always_comb begin
        w_idx = i_nb;
        for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
            if ((IDX_W'(i) < i_nb) &&
                (i_value <= blh_pkg::VAL_W'(i_bounds[i]))) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (i_op != blh_pkg::OP_NONE);
    assign o_item     = {i_op, i_value, w_idx};

endmodule

/* rtl/core/blh_div.sv */
module blh_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [blh_pkg::SUM_W-1:0] i_dividend,
    input  logic [blh_pkg::VAL_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [blh_pkg::SUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(blh_pkg::SUM_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [blh_pkg::VAL_W-1:0] r_rem;
    logic [blh_pkg::VAL_W-1:0] r_dvs;
    logic [blh_pkg::SUM_W-1:0] r_quo;
    logic [blh_pkg::VAL_W:0]   w_shift;
    logic [blh_pkg::VAL_W:0]   w_diff;
    logic                      w_ge;

    assign w_shift    = {r_rem, r_quo[blh_pkg::SUM_W-1]};
    assign w_diff     = w_shift - {1'b0, r_dvs};
    assign w_ge       = (w_shift >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[blh_pkg::VAL_W-1:0] : w_shift[blh_pkg::VAL_W-1:0];
            r_quo <= {r_quo[blh_pkg::SUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(blh_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/blh_back.sv */
module blh_back #(
    parameter int MAX_BOUNDS = blh_pkg::MAX_BOUNDS_DEF,
    parameter int IDX_W      = $clog2(MAX_BOUNDS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  logic [blh_pkg::OP_W+blh_pkg::VAL_W+IDX_W-1:0] i_q_data,
    output logic                                 o_pop,
    input  blh_pkg::t_bounds                     i_bounds,
    input  logic [IDX_W-1:0]                     i_nb,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [blh_pkg::VAL_W-1:0]            o_sample_count,
    output logic [blh_pkg::SUM_W-1:0]            o_value_sum,
    output logic [blh_pkg::VAL_W-1:0]            o_smallest,
    output logic [blh_pkg::VAL_W-1:0]            o_largest,
    output logic [blh_pkg::VAL_W-1:0]            o_average,
    output logic [blh_pkg::VAL_W-1:0]            o_median_estimate,
    output logic [blh_pkg::VAL_W-1:0]            o_p95_estimate,
    output logic [blh_pkg::VAL_W-1:0]            o_p99_estimate,
    output logic                                 o_is_empty
);

    localparam int VW     = blh_pkg::VAL_W;
    localparam int SW     = blh_pkg::SUM_W;
    localparam int DATA_W = blh_pkg::OP_W + VW + IDX_W;
    localparam int MEM_D  = MAX_BOUNDS + 1;
    localparam int CUM_W  = VW + $clog2(MAX_BOUNDS + 1);
    localparam int CMP_W  = CUM_W + blh_pkg::PCT_W;
    localparam int NPCT   = 3;

    typedef enum logic [5:0] {
        S_RUN   = 6'b000001,
        S_DIV   = 6'b000010,
        S_MUL   = 6'b000100,
        S_WREAD = 6'b001000,
        S_WACC  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                     r_state;
    logic                       r_a_vld;
    logic [IDX_W-1:0]           r_a_idx;
    logic [MEM_D-1:0]           r_cnt_vld;
    logic [VW-1:0]              r_mem [MEM_D];
    logic [VW-1:0]              r_mem_q;
    logic                       r_rd_vld;
    logic                       r_fwd_hit;
    logic [VW-1:0]              r_fwd_data;
    logic [VW-1:0]              r_count;
    logic [SW-1:0]              r_sum;
    logic [VW-1:0]              r_min;
    logic [VW-1:0]              r_max;
    logic [VW-1:0]              r_avg;
    logic [blh_pkg::PROD_W-1:0] r_tgt [NPCT];
    logic [VW-1:0]              r_est [NPCT];
    logic [NPCT-1:0]            r_found;
    logic                       r_div_start;
    logic [IDX_W-1:0]           r_wi;
    logic [CUM_W-1:0]           r_cum;
    logic                       r_out_valid;
    logic [VW-1:0]              r_o_count;
    logic [SW-1:0]              r_o_sum;
    logic [VW-1:0]              r_o_min;
    logic [VW-1:0]              r_o_max;
    logic [VW-1:0]              r_o_avg;
    logic [VW-1:0]              r_o_est [NPCT];
    logic                       r_o_empty;

    logic [blh_pkg::OP_W-1:0]   h_op;
    logic [VW-1:0]              h_val;
    logic [IDX_W-1:0]           h_idx;
    logic                       w_pop;
    logic                       w_rec;
    logic                       w_clr;
    logic                       w_snap;
    logic [IDX_W-1:0]           w_rd_addr;
    logic [VW-1:0]              w_rd_data;
    logic [VW-1:0]              w_wr_data;
    logic [SW:0]                w_add;
    logic [SW-1:0]              n_sum;
    logic [CUM_W-1:0]           n_cum;
    logic [CMP_W-1:0]           w_cum_x100;
    logic [NPCT-1:0]            w_hit;
    logic [VW-1:0]              w_bval;
    logic [VW-1:0]              w_b0;
    logic                       w_div_done;
    logic [SW-1:0]              w_div_quo;
    logic                       w_load;
    logic                       w_empty;

    assign h_op  = i_q_data[DATA_W-1 -: blh_pkg::OP_W];
    assign h_val = i_q_data[IDX_W +: VW];
    assign h_idx = i_q_data[IDX_W-1:0];

    assign w_pop  = (r_state == S_RUN) && !i_q_empty &&
                    ((h_op == blh_pkg::OP_RECORD) || !r_a_vld);
    assign w_rec  = w_pop && (h_op == blh_pkg::OP_RECORD);
    assign w_clr  = w_pop && (h_op == blh_pkg::OP_CLEAR);
    assign w_snap = w_pop && (h_op == blh_pkg::OP_SNAPSHOT);
    assign o_pop  = w_pop;

    assign w_rd_addr = (r_state == S_WREAD) ? r_wi : h_idx;
    assign w_rd_data = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_mem_q : '0);
    assign w_wr_data = (w_rd_data == '1) ? w_rd_data : VW'(w_rd_data + 1'b1);

    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_mem[r_a_idx] <= w_wr_data;
        end
        r_mem_q    <= r_mem[w_rd_addr];
        r_rd_vld   <= r_cnt_vld[w_rd_addr];
        r_fwd_hit  <= r_a_vld && (r_a_idx == w_rd_addr);
        r_fwd_data <= w_wr_data;
    end

    assign w_add = {1'b0, r_sum} + (SW + 1)'(h_val);
    assign n_sum = w_add[SW] ? '1 : w_add[SW-1:0];

    assign w_b0 = VW'(i_bounds[0]);

    always_comb begin
        if (r_wi == '0) begin
            w_bval = (r_min < w_b0) ? r_min : w_b0;
        end else if (r_wi < i_nb) begin
            w_bval = VW'(i_bounds[blh_pkg::SLOT_W'(r_wi)]);
        end else begin
            w_bval = r_max;
        end
    end

    assign n_cum = r_cum + CUM_W'(w_rd_data);

    // The walk compares 100 times the running count against pct times the
    // sample count, which reaches the rounded-up target with no divide.
    assign w_cum_x100 = (CMP_W'(n_cum) << 6) + (CMP_W'(n_cum) << 5) +
                        (CMP_W'(n_cum) << 2);

    always_comb begin
        for (int k = 0; k < NPCT; k++) begin
            w_hit[k] = (w_cum_x100 >= CMP_W'(r_tgt[k]));
        end
    end

    blh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign w_empty = (r_count == '0);
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && w_div_done) begin
            r_avg <= (w_div_quo[SW-1:VW] != '0) ? '1 : w_div_quo[VW-1:0];
        end
        if (r_state == S_MUL) begin
            r_tgt[0] <= blh_pkg::PROD_W'(blh_pkg::PCT_P50) * blh_pkg::PROD_W'(r_count);
            r_tgt[1] <= blh_pkg::PROD_W'(blh_pkg::PCT_P95) * blh_pkg::PROD_W'(r_count);
            r_tgt[2] <= blh_pkg::PROD_W'(blh_pkg::PCT_P99) * blh_pkg::PROD_W'(r_count);
            r_wi     <= '0;
            r_cum    <= '0;
        end
        if (r_state == S_WACC) begin
            r_cum <= n_cum;
            r_wi  <= IDX_W'(r_wi + 1'b1);
            for (int k = 0; k < NPCT; k++) begin
                if (!r_found[k] && w_hit[k]) begin
                    r_est[k] <= w_bval;
                end
            end
        end
        if (w_rec) begin
            r_a_idx <= h_idx;
        end
        if (w_load) begin
            r_o_count <= r_count;
            r_o_sum   <= r_sum;
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            r_o_avg   <= w_empty ? '0 : r_avg;
            r_o_empty <= w_empty;
            for (int k = 0; k < NPCT; k++) begin
                r_o_est[k] <= w_empty ? '0 : (r_found[k] ? r_est[k] : r_max);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_a_vld     <= 1'b0;
            r_cnt_vld   <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_found     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_a_vld     <= w_rec;
            if (r_a_vld) begin
                r_cnt_vld[r_a_idx] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (w_rec) begin
                        if (r_count != '1) begin
                            r_count <= VW'(r_count + 1'b1);
                        end
                        r_sum <= n_sum;
                        if (h_val < r_min) begin
                            r_min <= h_val;
                        end
                        if (h_val > r_max) begin
                            r_max <= h_val;
                        end
                    end else if (w_clr) begin
                        r_cnt_vld <= '0;
                        r_count   <= '0;
                        r_sum     <= '0;
                        r_min     <= '1;
                        r_max     <= '0;
                    end else if (w_snap) begin
                        if (w_empty) begin
                            r_state <= S_DONE;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_found <= '0;
                    r_state <= S_WREAD;
                end
                S_WREAD: begin
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    for (int k = 0; k < NPCT; k++) begin
                        if (w_hit[k]) begin
                            r_found[k] <= 1'b1;
                        end
                    end
                    r_state <= (r_wi == i_nb) ? S_DONE : S_WREAD;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_count    = r_o_count;
    assign o_value_sum       = r_o_sum;
    assign o_smallest        = r_o_min;
    assign o_largest         = r_o_max;
    assign o_average         = r_o_avg;
    assign o_median_estimate = r_o_est[0];
    assign o_p95_estimate    = r_o_est[1];
    assign o_p99_estimate    = r_o_est[2];
    assign o_is_empty        = r_o_empty;

endmodule
